### design/syshdr_pkg.sv
`default_nettype none
package syshdr_pkg;

  localparam int OFF_W = 11;
  localparam int DATE_LEN = 16;
  localparam int DATE_IDX_W = 5;
  localparam logic [DATE_IDX_W-1:0] DATE_END = DATE_IDX_W'(DATE_LEN);

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    K_LETTER,
    K_SPACE,
    K_NUMBER,
    K_SPACE_OR_NUMBER,
    K_COLON
  } kind_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_TOKEN,
    PH_DONE
  } phase_t;

  // timestamp pattern "Mmm dd hh:mm:ss "
  function automatic kind_t date_kind(input logic [3:0] idx);
    kind_t k;
    case (idx)
      4'd0, 4'd1, 4'd2: k = K_LETTER;
      4'd3, 4'd6, 4'd15: k = K_SPACE;
      4'd4, 4'd7, 4'd10, 4'd13: k = K_SPACE_OR_NUMBER;
      4'd9, 4'd12: k = K_COLON;
      default: k = K_NUMBER;
    endcase
    return k;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic date_ok(input logic [3:0] idx, input logic [7:0] c);
    logic digit;
    logic ok;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (date_kind(idx))
      K_LETTER: ok = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
      K_SPACE: ok = (c == CH_SPACE);
      K_NUMBER: ok = digit;
      K_SPACE_OR_NUMBER: ok = (c == CH_SPACE) || digit;
      default: ok = (c == CH_COLON);
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

### design/syslog_header_field_parser.sv
// Syslog header field parser: takes one message byte per cycle with no gaps needed and, after
// the beat carrying last passes the record queue and the result register, presents one result
// giving the timestamp flag and the tag, pid and text offsets. The byte scan never stalls on
// its own; full rises only when the two-entry record queue between the scanner and the result
// stage is full as results are not popped, so one byte per cycle holds while pop keeps up.
`default_nettype none
module syslog_header_field_parser #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last,
  output logic                         empty,
  input  wire logic                    pop,
  output logic                         date_skipped,
  output logic                         ident_found,
  output logic [syshdr_pkg::OFF_W-1:0] ident_start,
  output logic [syshdr_pkg::OFF_W-1:0] ident_len,
  output logic                         pid_found,
  output logic [syshdr_pkg::OFF_W-1:0] pid_start,
  output logic [syshdr_pkg::OFF_W-1:0] pid_len,
  output logic [syshdr_pkg::OFF_W-1:0] text_start,
  output logic                         too_long
);
  import syshdr_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int REC_W = 3 * POS_W + 21;

  logic             q_full;
  logic             rec_push;
  logic [REC_W-1:0] rec_in;
  logic [REC_W-1:0] rec_out;
  logic             rec_avail;
  logic             rec_pop;

  assign full = q_full;

  syshdr_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .busy      (q_full),
    .data_byte (data_byte),
    .last      (last),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  syshdr_queue #(.WIDTH(REC_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .full    (q_full),
    .rd_en   (rec_pop),
    .rd_data (rec_out),
    .avail   (rec_avail)
  );

  syshdr_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_avail    (rec_avail),
    .rec          (rec_out),
    .rec_pop      (rec_pop),
    .empty        (empty),
    .pop          (pop),
    .date_skipped (date_skipped),
    .ident_found  (ident_found),
    .ident_start  (ident_start),
    .ident_len    (ident_len),
    .pid_found    (pid_found),
    .pid_start    (pid_start),
    .pid_len      (pid_len),
    .text_start   (text_start),
    .too_long     (too_long)
  );

endmodule
`default_nettype wire

### design/syshdr_front.sv
`default_nettype none
module syshdr_front #(
  parameter int MAX_LEN = 1024,
  localparam int POS_W = $clog2(MAX_LEN + 1),
  localparam int REC_W = 3 * POS_W + 21
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             busy,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last,
  output logic                  rec_push,
  output logic [REC_W-1:0]      rec
);
  import syshdr_pkg::*;

  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic [15:0]      lb;
    logic             open_valid;
    logic [POS_W-1:0] open_pos;
    logic             sep;
  } ctx_t;

  typedef struct packed {
    logic             skipped;
    logic             too_long;
    logic             active;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic [15:0]      lb;
    logic             open_valid;
    logic [POS_W-1:0] open_pos;
    logic             sep;
  } rec_t;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
  localparam logic [POS_W-1:0] POS_DATE  = POS_W'(DATE_LEN);

  function automatic ctx_t ctx_clear();
    ctx_t y;
    y.phase      = PH_SKIP;
    y.start      = '0;
    y.len        = '0;
    y.lb         = '0;
    y.open_valid = 1'b0;
    y.open_pos   = '0;
    y.sep        = 1'b0;
    return y;
  endfunction

  function automatic ctx_t ctx_feed(input ctx_t x, input logic [7:0] c,
                                    input logic [POS_W-1:0] p);
    ctx_t y;
    logic grow;
    y = x;
    grow = 1'b0;
    case (x.phase)
      PH_SKIP: begin
        if (!is_ws(c)) begin
          y.phase = PH_TOKEN;
          y.start = p;
          y.len   = '0;
          grow    = 1'b1;
        end
      end
      PH_TOKEN: begin
        if (is_ws(c)) begin
          y.sep   = 1'b1;
          y.phase = PH_DONE;
        end else begin
          grow = 1'b1;
        end
      end
      default: ;
    endcase
    if (grow) begin
      y.len = y.len + 1'b1;
      y.lb  = {y.lb[7:0], c};
      if (c == CH_LBRACK) begin
        y.open_valid = 1'b1;
        y.open_pos   = p;
      end
    end
    return y;
  endfunction

  logic [POS_W-1:0]      pos, pos_next;
  logic [DATE_IDX_W-1:0] date_index, date_index_next;
  logic                  date_match, date_match_next;
  logic                  text_ended, text_ended_next;
  logic                  overflow, overflow_next;
  ctx_t                  cx0, cx0_next, cx1, cx1_next;
  logic                  take;
  rec_t                  r;

  assign take = push && !busy;

  always_comb begin
    pos_next        = pos;
    date_index_next = date_index;
    date_match_next = date_match;
    text_ended_next = text_ended;
    overflow_next   = overflow;
    cx0_next        = cx0;
    cx1_next        = cx1;
    if (pos >= POS_LIMIT) begin
      overflow_next = 1'b1;
    end else begin
      pos_next = pos + 1'b1;
      if (!text_ended) begin
        if (data_byte == 8'h00) begin
          text_ended_next = 1'b1;
          if (pos < POS_DATE) begin
            date_match_next = 1'b0;
          end
        end else begin
          if (pos < POS_DATE) begin
            if (!date_ok(pos[3:0], data_byte)) begin
              date_match_next = 1'b0;
            end
            if (date_index < DATE_END) begin
              date_index_next = date_index + 1'b1;
            end
          end
          cx0_next = ctx_feed(cx0, data_byte, pos);
          if (pos >= POS_DATE) begin
            cx1_next = ctx_feed(cx1, data_byte, pos);
          end
        end
      end
    end
  end

  always_comb begin
    ctx_t sel;
    r.skipped  = date_match_next && (date_index_next == DATE_END);
    sel        = r.skipped ? cx1_next : cx0_next;
    r.too_long   = overflow_next;
    r.active     = (sel.phase != PH_SKIP);
    r.start      = sel.start;
    r.len        = sel.len;
    r.lb         = sel.lb;
    r.open_valid = sel.open_valid;
    r.open_pos   = sel.open_pos;
    r.sep        = sel.sep;
  end

  assign rec      = r;
  assign rec_push = take && last;

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      pos        <= '0;
      date_index <= '0;
      date_match <= 1'b1;
      text_ended <= 1'b0;
      overflow   <= 1'b0;
      cx0        <= ctx_clear();
      cx1        <= ctx_clear();
    end else if (take) begin
      pos        <= pos_next;
      date_index <= date_index_next;
      date_match <= date_match_next;
      text_ended <= text_ended_next;
      overflow   <= overflow_next;
      cx0        <= cx0_next;
      cx1        <= cx1_next;
    end
  end

endmodule
`default_nettype wire

### design/syshdr_queue.sv
`default_nettype none
module syshdr_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  avail
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && avail;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/syshdr_back.sv
`default_nettype none
module syshdr_back #(
  parameter int MAX_LEN = 1024,
  localparam int POS_W = $clog2(MAX_LEN + 1),
  localparam int REC_W = 3 * POS_W + 21
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   rec_avail,
  input  wire logic [REC_W-1:0]       rec,
  output logic                        rec_pop,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        date_skipped,
  output logic                        ident_found,
  output logic [syshdr_pkg::OFF_W-1:0] ident_start,
  output logic [syshdr_pkg::OFF_W-1:0] ident_len,
  output logic                        pid_found,
  output logic [syshdr_pkg::OFF_W-1:0] pid_start,
  output logic [syshdr_pkg::OFF_W-1:0] pid_len,
  output logic [syshdr_pkg::OFF_W-1:0] text_start,
  output logic                        too_long
);
  import syshdr_pkg::*;

  typedef struct packed {
    logic             skipped;
    logic             too_long;
    logic             active;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic [15:0]      lb;
    logic             open_valid;
    logic [POS_W-1:0] open_pos;
    logic             sep;
  } rec_t;

  localparam int EXT_W = (POS_W + 1 > OFF_W) ? POS_W + 1 : OFF_W;

  rec_t             r;
  logic             out_valid;
  logic             load;
  logic [EXT_W-1:0] st, ln, op, tok_end, base;
  logic             ifound, pfound;
  logic [EXT_W-1:0] istart_w, ilen_w, pstart_w, plen_w, tstart_w;

  assign r       = rec;
  assign empty   = !out_valid;
  assign load    = rec_avail && (!out_valid || pop);
  assign rec_pop = load;

  always_comb begin
    st       = EXT_W'(r.start);
    ln       = EXT_W'(r.len);
    op       = EXT_W'(r.open_pos);
    tok_end  = st + ln;
    base     = r.skipped ? EXT_W'(DATE_LEN) : '0;
    ifound   = r.active && (r.len != '0) && (r.lb[7:0] == CH_COLON);
    pfound   = ifound && (ln >= EXT_W'(2)) && (r.lb[15:8] == CH_RBRACK) &&
               r.open_valid && (op >= st) && (op + EXT_W'(3) <= tok_end);
    istart_w = ifound ? st : '0;
    ilen_w   = '0;
    pstart_w = '0;
    plen_w   = '0;
    tstart_w = base;
    if (ifound) begin
      ilen_w   = ln - EXT_W'(1);
      tstart_w = tok_end + EXT_W'(r.sep);
    end
    if (pfound) begin
      ilen_w   = op - st;
      pstart_w = op + EXT_W'(1);
      plen_w   = tok_end - EXT_W'(3) - op;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      date_skipped <= r.skipped;
      ident_found  <= ifound;
      ident_start  <= istart_w[OFF_W-1:0];
      ident_len    <= ilen_w[OFF_W-1:0];
      pid_found    <= pfound;
      pid_start    <= pstart_w[OFF_W-1:0];
      pid_len      <= plen_w[OFF_W-1:0];
      text_start   <= tstart_w[OFF_W-1:0];
      too_long     <= r.too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/syshdr_checker.sv
`default_nettype none
module syshdr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic                         ident_found,
  input wire logic [syshdr_pkg::OFF_W-1:0] ident_start,
  input wire logic [syshdr_pkg::OFF_W-1:0] ident_len,
  input wire logic                         pid_found,
  input wire logic [syshdr_pkg::OFF_W-1:0] pid_start,
  input wire logic [syshdr_pkg::OFF_W-1:0] pid_len,
  input wire logic [syshdr_pkg::OFF_W-1:0] text_start
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(text_start) && $stable(ident_len)))
    else $error("waiting result changed");

  a_no_ident: assert property (@(posedge clk) disable iff (rst)
    (!empty && !ident_found) |-> (ident_start == '0 && ident_len == '0 && !pid_found))
    else $error("tag fields set without a tag");

  a_no_pid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pid_found) |-> (pid_start == '0 && pid_len == '0))
    else $error("pid fields set without a pid");

  a_pid_after_tag: assert property (@(posedge clk) disable iff (rst)
    (!empty && pid_found) |-> (pid_start == ident_start + ident_len + 1'b1))
    else $error("pid does not follow the tag bracket");

endmodule

bind syslog_header_field_parser syshdr_checker u_chk (.*);
`default_nettype wire

### test/syslog_header_field_parser_tb.sv
module syslog_header_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import syshdr_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam int QUIET_LIMIT = 4000;
  // timestamp shape: A letter, D digit, d space or digit
  localparam logic [8*16-1:0] STAMP = "AAA dD dD:dD:dD ";

  typedef struct packed {
    logic               date_skipped;
    logic               ident_found;
    logic [OFF_W-1:0]   ident_start;
    logic [OFF_W-1:0]   ident_len;
    logic               pid_found;
    logic [OFF_W-1:0]   pid_start;
    logic [OFF_W-1:0]   pid_len;
    logic [OFF_W-1:0]   text_start;
    logic               too_long;
  } hdr_t;

  typedef struct packed {
    phase_t           ph;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] len;
    logic [15:0]      tail;
    logic             br_ok;
    logic [OFF_W-1:0] br_pos;
    logic             sep;
  } tok_ctx_t;

  typedef struct {
    logic [7:0] b;
    bit         fin;
    int         row;
  } beat_t;

  typedef struct {
    string      text;
    int         fill_n;
    logic [7:0] fill_c;
    bit         typed;
    hdr_t       want;
  } dir_row_t;

  // '~' in the text stands for a zero byte
  dir_row_t dir_rows [18] = '{
    '{"x", 0, 8'h00, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{"Oct 11 22:14:15 su[123]: hello", 0, 8'h00, 1'b1, '{1, 1, 16, 2, 1, 19, 3, 25, 0}},
    '{"Oct 11 22:14:15 ", 0, 8'h00, 1'b1, '{1, 0, 0, 0, 0, 0, 0, 16, 0}},
    '{"Oct 11 22:14:15 mymachine su: test", 0, 8'h00, 1'b0, '0},
    '{"Feb  5 01:02:03 cron:", 0, 8'h00, 1'b0, '0},
    '{"kernel: boot", 0, 8'h00, 1'b0, '0},
    '{" \t\r\nabc[]: x", 0, 8'h00, 1'b0, '0},
    '{"a[b[c]:\tz", 0, 8'h00, 1'b0, '0},
    '{":", 0, 8'h00, 1'b0, '0},
    '{"[1]:", 0, 8'h00, 1'b0, '0},
    '{"a[1]", 0, 8'h00, 1'b0, '0},
    '{"Oct 11 22:14:15", 0, 8'h00, 1'b0, '0},
    '{"abc:~ def", 0, 8'h00, 1'b0, '0},
    '{"Oct 11 22:1~4:15 t: x", 0, 8'h00, 1'b0, '0},
    '{"Oct 11 22:14:15 ~ab:", 0, 8'h00, 1'b0, '0},
    '{"Xyz 99 99:99:99 t: x", 0, 8'h00, 1'b0, '0},
    '{"q: ", 1021, 8'h7A, 1'b1, '{0, 1, 0, 1, 0, 0, 0, 3, 0}},
    '{"q: ", 1022, 8'h7A, 1'b1, '{0, 1, 0, 1, 0, 0, 0, 3, 1}}
  };

  int tx_pct [3] = '{31, 54, 0};
  int rx_pct [3] = '{54, 31, 0};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       data_byte = 8'h00;
  logic             last = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic             date_skipped;
  logic             ident_found;
  logic [OFF_W-1:0] ident_start;
  logic [OFF_W-1:0] ident_len;
  logic             pid_found;
  logic [OFF_W-1:0] pid_start;
  logic [OFF_W-1:0] pid_len;
  logic [OFF_W-1:0] text_start;
  logic             too_long;

  beat_t byte_q[$];
  hdr_t  pending_hdrs[$];
  int    errors = 0;
  int    tx_idle = 0;
  int    rx_idle = 0;
  bit    running = 1'b0;
  int    quiet = 0;

  // predictor state
  logic [OFF_W-1:0] scan_pos;
  logic [4:0]       date_cnt;
  bit               date_good;
  bit               text_done;
  bit               over_seen;
  tok_ctx_t         tok [2];

  syslog_header_field_parser #(.MAX_LEN(MAX_LEN)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte), .last(last),
    .empty(empty), .pop(pop), .date_skipped(date_skipped), .ident_found(ident_found),
    .ident_start(ident_start), .ident_len(ident_len), .pid_found(pid_found),
    .pid_start(pid_start), .pid_len(pid_len), .text_start(text_start), .too_long(too_long)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit stamp_fits(int i, logic [7:0] c);
    bit dig;
    dig = c >= CH_ZERO && c <= CH_NINE;
    case (STAMP[8*(15-i) +: 8])
      "A": return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      "D": return dig;
      "d": return dig || c == CH_SPACE;
      " ": return c == CH_SPACE;
      default: return c == CH_COLON;
    endcase
  endfunction

  function automatic void clear_scan();
    scan_pos = '0;
    date_cnt = '0;
    date_good = 1'b1;
    text_done = 1'b0;
    over_seen = 1'b0;
    for (int k = 0; k < 2; k++) begin
      tok[k] = '0;
      tok[k].ph = PH_SKIP;
    end
  endfunction

  function automatic void tok_feed(inout tok_ctx_t t, input logic [7:0] c,
                                   input logic [OFF_W-1:0] at);
    if (t.ph == PH_DONE) return;
    if (blank(c)) begin
      if (t.ph == PH_TOKEN) begin
        t.sep = 1'b1;
        t.ph = PH_DONE;
      end
      return;
    end
    if (t.ph == PH_SKIP) begin
      t.ph = PH_TOKEN;
      t.start = at;
      t.len = '0;
    end
    t.len++;
    t.tail = {t.tail[7:0], c};
    if (c == CH_LBRACK) begin
      t.br_ok = 1'b1;
      t.br_pos = at;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input bit fin,
                                     output bit got, output hdr_t r);
    logic [OFF_W-1:0] at;
    bit skip;
    tok_ctx_t t;
    got = fin;
    r = '0;
    if (scan_pos >= MAX_LEN) begin
      over_seen = 1'b1;
    end else begin
      at = scan_pos;
      scan_pos++;
      if (!text_done) begin
        if (c == 8'h00) begin
          text_done = 1'b1;
          if (at < DATE_LEN) date_good = 1'b0;
        end else begin
          if (at < DATE_LEN) begin
            if (!stamp_fits(at, c)) date_good = 1'b0;
            if (date_cnt < DATE_LEN) date_cnt++;
          end
          tok_feed(tok[0], c, at);
          if (at >= DATE_LEN) tok_feed(tok[1], c, at);
        end
      end
    end
    if (fin) begin
      skip = date_good && date_cnt == DATE_LEN;
      t = tok[skip];
      r.date_skipped = skip;
      r.too_long = over_seen;
      r.text_start = skip ? OFF_W'(DATE_LEN) : '0;
      if (t.ph != PH_SKIP && t.len != 0 && t.tail[7:0] == CH_COLON) begin
        r.ident_found = 1'b1;
        r.ident_start = t.start;
        r.ident_len = t.len - 1'b1;
        if (t.len >= 2 && t.tail[15:8] == CH_RBRACK && t.br_ok && t.br_pos >= t.start &&
            t.br_pos + 3 <= t.start + t.len) begin
          r.pid_found = 1'b1;
          r.pid_start = t.br_pos + 1'b1;
          r.pid_len = OFF_W'(t.start + t.len - 3 - t.br_pos);
          r.ident_len = t.br_pos - t.start;
        end
        r.text_start = t.start + t.len + t.sep;
      end
      clear_scan();
    end
  endfunction

  function automatic void queue_msg(input logic [7:0] m[$], input int row);
    for (int k = 0; k < m.size(); k++)
      byte_q.push_back('{m[k], k == m.size() - 1, row});
  endfunction

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // one random message; returns how many of its bytes the parser will look at
  function automatic int add_msg();
    logic [7:0] m[$];
    logic [7:0] ch;
    int shape;
    int n;
    int target;
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      n = $urandom_range(1, 40);
      repeat (n) m.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (shape < 80) begin
        for (int i = 0; i < 16; i++) begin
          case (STAMP[8*(15-i) +: 8])
            "A": ch = 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
            "D": ch = 8'(CH_ZERO + $urandom_range(0, 9));
            "d": ch = ($urandom_range(0, 3) == 0) ? CH_SPACE :
                                                    8'(CH_ZERO + $urandom_range(0, 9));
            " ": ch = CH_SPACE;
            default: ch = CH_COLON;
          endcase
          m.push_back(ch);
        end
        if (shape >= 68) m[$urandom_range(0, 15)] = 8'($urandom_range(0, 255));
      end
      repeat ($urandom_range(0, 2)) m.push_back(ws_byte());
      n = $urandom_range(0, 8);
      repeat (n) begin
        ch = 8'($urandom_range(8'h21, 8'h7E));
        if (ch == CH_COLON) ch = 8'h61;
        if ($urandom_range(0, 9) == 0) ch = CH_LBRACK;
        m.push_back(ch);
      end
      if ($urandom_range(0, 1)) begin
        m.push_back(CH_LBRACK);
        repeat ($urandom_range(0, 5)) m.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        m.push_back(CH_RBRACK);
      end
      if ($urandom_range(0, 99) < 85) m.push_back(CH_COLON);
      if ($urandom_range(0, 99) < 80) m.push_back(ws_byte());
      repeat ($urandom_range(0, 20))
        m.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) :
                                                  8'($urandom_range(8'h20, 8'h7E)));
      if (m.size() == 0) m.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) m[$urandom_range(0, m.size() - 1)] = 8'h00;
      if ($urandom_range(0, 19) == 0 && m.size() > 1) begin
        target = $urandom_range(1, m.size() - 1);
        while (m.size() > target) void'(m.pop_back());
      end
    end
    if ($urandom_range(0, 99) < 2) begin
      target = MAX_LEN + $urandom_range(1, 8);
      while (m.size() < target) m.push_back(8'($urandom_range(0, 255)));
    end
    queue_msg(m, -1);
    return (m.size() < MAX_LEN) ? m.size() : MAX_LEN;
  endfunction

  function automatic void cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    hdr_t p;
    bit got;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_byte(byte_q[0].b, byte_q[0].fin, got, p);
        if (got) begin
          if (byte_q[0].row >= 0 && dir_rows[byte_q[0].row].typed)
            pending_hdrs.push_back(dir_rows[byte_q[0].row].want);
          else
            pending_hdrs.push_back(p);
        end
        void'(byte_q.pop_front());
      end
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        push <= 1'b1;
        data_byte <= byte_q[0].b;
        last <= byte_q[0].fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    hdr_t w;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_hdrs.size() == 0) begin
          $display("%0t result beat with none expected", $time);
          errors++;
        end else begin
          w = pending_hdrs.pop_front();
          cmp("date_skipped", w.date_skipped, date_skipped);
          cmp("ident_found", w.ident_found, ident_found);
          cmp("ident_start", w.ident_start, ident_start);
          cmp("ident_len", w.ident_len, ident_len);
          cmp("pid_found", w.pid_found, pid_found);
          cmp("pid_start", w.pid_start, pid_start);
          cmp("pid_len", w.pid_len, pid_len);
          cmp("text_start", w.text_start, text_start);
          cmp("too_long", w.too_long, too_long);
        end
      end
      pop <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!running || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [7:0] m[$];
    logic [7:0] ch;
    int fed;
    int n;
    clear_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      running = 1'b1;
      tx_idle = tx_pct[ph];
      rx_idle = rx_pct[ph];
      if (ph == 0) begin
        foreach (dir_rows[r]) begin
          m = {};
          for (int i = 0; i < dir_rows[r].text.len(); i++) begin
            ch = dir_rows[r].text[i];
            m.push_back((ch == "~") ? 8'h00 : ch);
          end
          repeat (dir_rows[r].fill_n) m.push_back(dir_rows[r].fill_c);
          queue_msg(m, r);
        end
      end
      fed = 0;
      n = 0;
      while (fed < 434 || n < 14) begin
        fed += add_msg();
        n++;
      end
      while (byte_q.size() != 0 || pending_hdrs.size() != 0) @(negedge clk);
    end
    running = 1'b0;
    repeat (20) @(negedge clk);
    if (errors == 0 && pending_hdrs.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
design/syshdr_pkg.sv
design/syshdr_front.sv
design/syshdr_queue.sv
design/syshdr_back.sv
design/syslog_header_field_parser.sv
design/syshdr_checker.sv
test/syslog_header_field_parser_tb.sv
